// File: sv/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// Types, character codes and byte classification for the lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pil_pkg;

	localparam int POS_BITS_DEF = 16;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// token type codes
	localparam logic [4:0] TOK_UNKNOWN = 5'd0;
	localparam logic [4:0] TOK_HASH    = 5'd1;
	localparam logic [4:0] TOK_DOT     = 5'd2;
	localparam logic [4:0] TOK_COMMA   = 5'd3;
	localparam logic [4:0] TOK_EQUAL   = 5'd4;
	localparam logic [4:0] TOK_COLON   = 5'd5;
	localparam logic [4:0] TOK_SEMI    = 5'd6;
	localparam logic [4:0] TOK_QUOTE   = 5'd7;
	localparam logic [4:0] TOK_LBRACE  = 5'd8;
	localparam logic [4:0] TOK_RBRACE  = 5'd9;
	localparam logic [4:0] TOK_LPAREN  = 5'd10;
	localparam logic [4:0] TOK_RPAREN  = 5'd11;
	localparam logic [4:0] TOK_LBRACK  = 5'd12;
	localparam logic [4:0] TOK_RBRACK  = 5'd13;
	localparam logic [4:0] TOK_LANGLE  = 5'd14;
	localparam logic [4:0] TOK_RANGLE  = 5'd15;
	localparam logic [4:0] TOK_IDENT   = 5'd16;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_RANGLE = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  tok_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic in_identifier;
		logic star_pending;
	} lex_flags_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
	endfunction

	function automatic logic is_ident_char(input logic [7:0] b);
		return is_letter(b) || (b >= CH_ZERO && b <= CH_NINE) || b == CH_UNDER || b == CH_STAR;
	endfunction

	function automatic logic is_skipped(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_NUL;
	endfunction

	function automatic logic [4:0] punct_code(input logic [7:0] b);
		logic [4:0] code;
		case (b)
			CH_HASH:   code = TOK_HASH;
			CH_DOT:    code = TOK_DOT;
			CH_COMMA:  code = TOK_COMMA;
			CH_EQUAL:  code = TOK_EQUAL;
			CH_COLON:  code = TOK_COLON;
			CH_SEMI:   code = TOK_SEMI;
			CH_QUOTE:  code = TOK_QUOTE;
			CH_LBRACE: code = TOK_LBRACE;
			CH_RBRACE: code = TOK_RBRACE;
			CH_LPAREN: code = TOK_LPAREN;
			CH_RPAREN: code = TOK_RPAREN;
			CH_LBRACK: code = TOK_LBRACK;
			CH_RBRACK: code = TOK_RBRACK;
			CH_LANGLE: code = TOK_LANGLE;
			CH_RANGLE: code = TOK_RANGLE;
			default:   code = TOK_UNKNOWN;
		endcase
		return code;
	endfunction

	function automatic out_item_t make_token(input logic [4:0] t, input logic [15:0] s,
			input logic [15:0] l);
		out_item_t tok;
		tok.tok_kind     = t;
		tok.token_start  = s;
		tok.token_length = l;
		tok.last_of_run  = 1'b0;
		return tok;
	endfunction

endpackage

// File: sv/pil_step.sv
// ----------------------------------------------------------------------------
// pil_step
// Combinational lexer step: one byte against the current state gives the
// next state and up to two tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pil_step #(
	parameter int POS_BITS = pil_pkg::POS_BITS_DEF
) (
	input  logic [7:0]              data_byte,
	input  logic                    end_of_buffer,
	input  pil_pkg::lex_flags_t     flags,
	input  logic [POS_BITS-1:0]     open_start,
	input  logic [15:0]             open_length,
	input  logic [POS_BITS-1:0]     position,
	output pil_pkg::lex_flags_t     nxt_flags,
	output logic [POS_BITS-1:0]     nxt_open_start,
	output logic [15:0]             nxt_open_length,
	output logic [POS_BITS-1:0]     nxt_position,
	output pil_pkg::out_item_t      res_a,
	output pil_pkg::out_item_t      res_b,
	output logic [1:0]              res_count
);
	import pil_pkg::*;

	logic                id;
	logic                sp;
	logic                consumed;
	logic [POS_BITS-1:0] os;
	logic [15:0]         ol;
	logic [1:0]          n;
	logic [4:0]          code;
	out_item_t           tok;
	out_item_t           ra;
	out_item_t           rb;

	always_comb begin
		id       = flags.in_identifier;
		sp       = flags.star_pending;
		os       = open_start;
		ol       = open_length;
		consumed = 1'b0;
		n        = 2'd0;
		ra       = '0;
		rb       = '0;
		tok      = '0;
		code     = punct_code(data_byte);

		// pending star: a following space makes it a lone unknown byte
		if (sp) begin
			sp = 1'b0;
			if (data_byte == CH_SPACE) begin
				tok = make_token(TOK_UNKNOWN, 16'(os), 16'd1);
				if (n == 2'd0) ra = tok; else rb = tok;
				n = n + 2'd1;
			end else begin
				id = 1'b1;
			end
		end

		if (id) begin
			if (is_ident_char(data_byte)) begin
				if (ol != LEN_MAX)
					ol = ol + 16'd1;
				consumed = 1'b1;
			end else begin
				tok = make_token(TOK_IDENT, 16'(os), ol);
				if (n == 2'd0) ra = tok; else rb = tok;
				n  = n + 2'd1;
				id = 1'b0;
			end
		end

		if (!consumed && !is_skipped(data_byte)) begin
			if (code != TOK_UNKNOWN) begin
				tok = make_token(code, 16'(position), 16'd1);
				if (n == 2'd0) ra = tok; else rb = tok;
				n = n + 2'd1;
			end else if (is_letter(data_byte)) begin
				id = 1'b1;
				os = position;
				ol = 16'd1;
			end else if (data_byte == CH_STAR) begin
				sp = 1'b1;
				os = position;
				ol = 16'd1;
			end else begin
				tok = make_token(TOK_UNKNOWN, 16'(position), 16'd1);
				if (n == 2'd0) ra = tok; else rb = tok;
				n = n + 2'd1;
			end
		end

		if (end_of_buffer) begin
			// flush: a pending star counts as a one-byte identifier
			if (sp || id) begin
				tok = make_token(TOK_IDENT, 16'(os), sp ? 16'd1 : ol);
				if (n == 2'd0) ra = tok; else rb = tok;
				n = n + 2'd1;
			end
			id           = 1'b0;
			sp           = 1'b0;
			os           = '0;
			ol           = '0;
			nxt_position = '0;
		end else begin
			nxt_position = position + POS_BITS'(1);
		end

		ra.last_of_run = (n == 2'd1);
		rb.last_of_run = 1'b1;

		nxt_flags.in_identifier = id;
		nxt_flags.star_pending  = sp;
		nxt_open_start          = os;
		nxt_open_length         = ol;
		res_a                   = ra;
		res_b                   = rb;
		res_count               = n;
	end

endmodule

// File: sv/pil_token_fifo.sv
// ----------------------------------------------------------------------------
// pil_token_fifo
// Four-entry token queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pil_token_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_count,
	input  pil_pkg::out_item_t push_a,
	input  pil_pkg::out_item_t push_b,
	output logic               room,
	output logic               token_valid,
	input  logic               token_ready,
	output pil_pkg::out_item_t token
);
	import pil_pkg::*;

	out_item_t  mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop         = token_valid && token_ready;
	assign token_valid = (cnt_q != 3'd0);
	assign token       = mem_q[rd_ptr_q];
	// two free slots needed, as one item may push two tokens
	assign room        = (cnt_q <= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_count;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			cnt_q    <= cnt_q + 3'(push_count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			mem_q[wr_ptr_q] <= push_a;
		if (push_count == 2'd2)
			mem_q[wr_ptr_q + 2'd1] <= push_b;
	end

endmodule

// File: sv/punctuation_identifier_lexer.sv
// ----------------------------------------------------------------------------
// punctuation_identifier_lexer
// Streaming lexer: one text byte per item in, tokens (type, start, length) out.
// ----------------------------------------------------------------------------
// A byte is held in the input stage register, then its tokens are written
// into the token queue. Throughput: one byte per cycle while the 4-entry
// queue has room for two tokens; the output port drains one token at a time.
// Reset: clears the lexer state, byte offset, input stage and token queue.
`timescale 1ns / 1ps

module punctuation_identifier_lexer #(
	parameter int POS_BITS = pil_pkg::POS_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  pil_pkg::in_item_t  item,
	output logic               token_valid,
	input  logic               token_ready,
	output pil_pkg::out_item_t token
);
	import pil_pkg::*;

	in_item_t            item_s1;
	logic                valid_s1;
	lex_flags_t          flags_q;
	logic [POS_BITS-1:0] open_start_q;
	logic [15:0]         open_length_q;
	logic [POS_BITS-1:0] position_q;

	lex_flags_t          nxt_flags;
	logic [POS_BITS-1:0] nxt_open_start;
	logic [15:0]         nxt_open_length;
	logic [POS_BITS-1:0] nxt_position;
	out_item_t           res_a;
	out_item_t           res_b;
	logic [1:0]          res_count;
	logic                room;
	logic                step_fire;

	assign step_fire  = valid_s1 && room;
	assign item_ready = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			open_start_q  <= '0;
			open_length_q <= '0;
			position_q    <= '0;
		end else if (step_fire) begin
			flags_q       <= nxt_flags;
			open_start_q  <= nxt_open_start;
			open_length_q <= nxt_open_length;
			position_q    <= nxt_position;
		end
	end

	pil_step #(
		.POS_BITS(POS_BITS)
	) u_step (
		.data_byte       (item_s1.data_byte),
		.end_of_buffer   (item_s1.end_of_buffer),
		.flags           (flags_q),
		.open_start      (open_start_q),
		.open_length     (open_length_q),
		.position        (position_q),
		.nxt_flags       (nxt_flags),
		.nxt_open_start  (nxt_open_start),
		.nxt_open_length (nxt_open_length),
		.nxt_position    (nxt_position),
		.res_a           (res_a),
		.res_b           (res_b),
		.res_count       (res_count)
	);

	pil_token_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_count  (step_fire ? res_count : 2'd0),
		.push_a      (res_a),
		.push_b      (res_b),
		.room        (room),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token)
	);

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams text bytes through the lexer and checks every token against an
// in-bench lexer model. It runs a directed pass, then random buffers. Both
// handshakes idle in random bursts, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pil_pkg::*;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      token_valid;
	logic      token_ready = 1'b0;
	out_item_t token;

	punctuation_identifier_lexer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token      (token)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	in_item_t  pending_bytes[$];
	out_item_t expected_tokens[$];
	out_item_t want;
	logic      failed = 1'b0;
	logic      in_taken = 1'b0;
	logic      idle_on = 1'b1;
	logic      hold_armed = 1'b0;
	logic      hold_done = 1'b0;
	int        hold_left = 0;
	int        send_gap = 0;
	int        ready_gap = 0;
	int        text_bytes = 0;

	// lexer model state
	logic        lx_in_ident = 1'b0;
	logic        lx_star = 1'b0;
	logic [15:0] lx_start = '0;
	logic [15:0] lx_len = '0;
	logic [15:0] lx_pos = '0;

	logic [7:0] punct_chars[15] = '{CH_HASH, CH_DOT, CH_COMMA, CH_EQUAL, CH_COLON,
		CH_SEMI, CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK,
		CH_RBRACK, CH_LANGLE, CH_RANGLE};

	function automatic logic letter(input logic [7:0] b);
		logic [7:0] folded;
		folded = b | 8'h20;
		return folded >= CH_LOWER_A && folded <= CH_LOWER_Z;
	endfunction

	function automatic logic ident_char(input logic [7:0] b);
		if (letter(b) || b == CH_UNDER || b == CH_STAR)
			return 1'b1;
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic logic skip_byte(input logic [7:0] b);
		case (b)
			CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_NUL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [4:0] punct_type(input logic [7:0] b);
		logic [4:0] t;
		t = TOK_UNKNOWN;
		for (int i = 0; i < 15; i++)
			if (punct_chars[i] == b)
				t = TOK_HASH + 5'(i);
		return t;
	endfunction

	// one text byte in, zero to two tokens appended to expected_tokens
	task automatic lex_byte(input in_item_t it);
		out_item_t  toks[2];
		int         n;
		int         k;
		logic       eaten;
		logic [7:0] b;
		logic [4:0] pt;
		n = 0;
		eaten = 1'b0;
		b = it.data_byte;
		if (lx_star) begin
			lx_star = 1'b0;
			if (b == CH_SPACE) begin
				toks[n] = {TOK_UNKNOWN, lx_start, 16'd1, 1'b0};
				n++;
			end else
				lx_in_ident = 1'b1;
		end
		if (lx_in_ident) begin
			if (ident_char(b)) begin
				if (lx_len != LEN_MAX)
					lx_len = lx_len + 16'd1;
				eaten = 1'b1;
			end else begin
				toks[n] = {TOK_IDENT, lx_start, lx_len, 1'b0};
				n++;
				lx_in_ident = 1'b0;
			end
		end
		if (!eaten && !skip_byte(b)) begin
			pt = punct_type(b);
			if (pt != TOK_UNKNOWN) begin
				toks[n] = {pt, lx_pos, 16'd1, 1'b0};
				n++;
			end else if (letter(b)) begin
				lx_in_ident = 1'b1;
				lx_start = lx_pos;
				lx_len = 16'd1;
			end else if (b == CH_STAR) begin
				lx_star = 1'b1;
				lx_start = lx_pos;
				lx_len = 16'd1;
			end else begin
				toks[n] = {TOK_UNKNOWN, lx_pos, 16'd1, 1'b0};
				n++;
			end
		end
		if (it.end_of_buffer) begin
			// a pending star at the end counts as an identifier of one byte
			if (lx_star) begin
				toks[n] = {TOK_IDENT, lx_start, 16'd1, 1'b0};
				n++;
			end else if (lx_in_ident) begin
				toks[n] = {TOK_IDENT, lx_start, lx_len, 1'b0};
				n++;
			end
			lx_in_ident = 1'b0;
			lx_star = 1'b0;
			lx_start = '0;
			lx_len = '0;
			lx_pos = '0;
		end else
			lx_pos = lx_pos + 16'd1;
		for (k = 0; k < n; k++) begin
			if (k == n - 1)
				toks[k].last_of_run = 1'b1;
			expected_tokens.push_back(toks[k]);
		end
	endtask

	always @(posedge clk) begin
		in_taken <= item_valid && item_ready;
		if (arst_n && item_valid && item_ready)
			lex_byte(item);
		if (arst_n && token_valid && token_ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: type %0d start %0d length %0d",
					token.tok_kind, token.token_start, token.token_length);
				failed = 1'b1;
			end else begin
				want = expected_tokens.pop_front();
				if (token.tok_kind !== want.tok_kind) begin
					$error("tok_kind expected %0d actual %0d", want.tok_kind,
						token.tok_kind);
					failed = 1'b1;
				end
				if (token.token_start !== want.token_start) begin
					$error("token_start expected %0d actual %0d", want.token_start,
						token.token_start);
					failed = 1'b1;
				end
				if (token.token_length !== want.token_length) begin
					$error("token_length expected %0d actual %0d", want.token_length,
						token.token_length);
					failed = 1'b1;
				end
				if (token.last_of_run !== want.last_of_run) begin
					$error("last_of_run expected %0d actual %0d", want.last_of_run,
						token.last_of_run);
					failed = 1'b1;
				end
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n)
			item_valid <= 1'b0;
		else if (!item_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_bytes.size() == 0)
				item_valid <= 1'b0;
			else if (idle_on && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 9);
				item_valid <= 1'b0;
			end else begin
				item <= pending_bytes.pop_front();
				item_valid <= 1'b1;
			end
		end
	end

	// token receiver
	always @(negedge clk) begin
		if (!arst_n)
			token_ready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			token_ready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			// long hold-off: lets the token queue fill and stall the input
			hold_done <= 1'b1;
			hold_left <= 399;
			token_ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap <= ready_gap - 1;
			token_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			ready_gap <= $urandom_range(0, 9);
			token_ready <= 1'b0;
		end else
			token_ready <= 1'b1;
	end

	task automatic push_byte(input logic [7:0] b, input logic eob);
		in_item_t it;
		it.data_byte = b;
		it.end_of_buffer = eob;
		pending_bytes.push_back(it);
		text_bytes++;
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return CH_LOWER_A + 8'($urandom_range(0, 25));
		return CH_UPPER_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_ident_char();
		case ($urandom_range(0, 5))
			2: return CH_ZERO + 8'($urandom_range(0, 9));
			3: return CH_UNDER;
			4: return CH_STAR;
			default: return rand_letter();
		endcase
	endfunction

	function automatic logic [7:0] rand_skip();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_CR;
			3: return CH_NUL;
			default: return CH_SPACE;
		endcase
	endfunction

	// one buffer of mostly well-formed words, end flag on its last byte
	task automatic gen_buffer();
		logic [7:0] text[$];
		int         words;
		int         k;
		words = $urandom_range(1, 12);
		repeat (words) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					text.push_back(rand_letter());
					repeat ($urandom_range(0, 8))
						text.push_back(rand_ident_char());
				end
				3: begin
					text.push_back(CH_STAR);
					repeat ($urandom_range(0, 5))
						text.push_back(rand_ident_char());
				end
				4: begin
					text.push_back(CH_STAR);
					text.push_back(CH_SPACE);
				end
				5, 6: text.push_back(punct_chars[$urandom_range(0, 14)]);
				7: repeat ($urandom_range(1, 3))
					text.push_back(rand_skip());
				8: text.push_back(8'($urandom_range(0, 255)));
				default: text.push_back(8'($urandom_range(128, 255)));
			endcase
			if ($urandom_range(0, 2) == 0)
				text.push_back(rand_skip());
		end
		for (k = 0; k < text.size(); k++)
			push_byte(text[k], k == text.size() - 1);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || item_valid || expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		string directed;
		int    i;
		directed = "#.,=:;\"{}()[]<>a_9*Z;* *q";
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all punctuation, identifier ended by punctuation, star cases, high byte,
		// NUL, and a star pending at the buffer end
		for (i = 0; i < directed.len(); i++)
			push_byte(directed[i], 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_NUL, 1'b0);
		push_byte(CH_STAR, 1'b1);
		wait_drained();

		hold_armed = 1'b1;
		text_bytes = 0;
		while (text_bytes < 950)
			gen_buffer();
		while (pending_bytes.size() > 8)
			@(posedge clk);
		idle_on = 1'b0;
		while (text_bytes < 1100)
			gen_buffer();

		while (pending_bytes.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
